// ----- rtl/mrtu_pkg.sv -----
// ----------------------------------------------------------------------------
// mrtu_pkg: shared types and constants for the Modbus RTU master frame engine
// Holds command, kind and status codes, frame byte positions, the CRC-16
// byte update and the structs passed between the engine's submodules.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  // Input command codes
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RX_BYTE = 1'b1;

  // Result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Report status codes
  localparam logic [2:0] ST_READ_OK  = 3'd0;
  localparam logic [2:0] ST_WRITE_OK = 3'd1;
  localparam logic [2:0] ST_SHORT    = 3'd2;
  localparam logic [2:0] ST_CRC_BAD  = 3'd3;
  localparam logic [2:0] ST_BAD_SLV  = 3'd4;
  localparam logic [2:0] ST_OTHER_FN = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;

  // Function codes
  localparam logic [7:0] FUNC_READ  = 8'h03;
  localparam logic [7:0] FUNC_WRITE = 8'h06;

  // Request frame byte positions
  localparam logic [2:0] TXB_SLAVE   = 3'd0;
  localparam logic [2:0] TXB_FUNC    = 3'd1;
  localparam logic [2:0] TXB_ADDR_HI = 3'd2;
  localparam logic [2:0] TXB_ADDR_LO = 3'd3;
  localparam logic [2:0] TXB_WORD_HI = 3'd4;
  localparam logic [2:0] TXB_WORD_LO = 3'd5;
  localparam logic [2:0] TXB_CRC_LO  = 3'd6;
  localparam logic [2:0] TXB_CRC_HI  = 3'd7;

  // CRC-16 (reflected 0xA001, preset all ones)
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Serializer status toward the output stage
  typedef struct packed {
    logic       busy;
    logic [7:0] data;
    logic       last;
  } mrtu_tx_t;

  // Response report toward the output stage
  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic [7:0]  slave;
    logic [15:0] value;
  } mrtu_rpt_t;

  // Fold one byte into the CRC, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/mrtu_tx_frame.sv -----
// ----------------------------------------------------------------------------
// mrtu_tx_frame: request frame serializer
// Latches one request and hands out its eight bytes one per advance, folding
// the six header bytes into the CRC as they leave.
// ----------------------------------------------------------------------------
module mrtu_tx_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [7:0]          slave,
  input  logic [7:0]          func,
  input  logic [15:0]         start_addr,
  input  logic [15:0]         word,
  input  logic                advance,
  output mrtu_pkg::mrtu_tx_t  tx_st
);
  import mrtu_pkg::*;

  logic        busy_r, busy_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  slave_r, func_r;
  logic [15:0] addr_r, word_r;
  logic [7:0]  cur_byte;
  logic        is_hdr;

  always_comb begin
    unique case (idx_r)
      TXB_SLAVE:   cur_byte = slave_r;
      TXB_FUNC:    cur_byte = func_r;
      TXB_ADDR_HI: cur_byte = addr_r[15:8];
      TXB_ADDR_LO: cur_byte = addr_r[7:0];
      TXB_WORD_HI: cur_byte = word_r[15:8];
      TXB_WORD_LO: cur_byte = word_r[7:0];
      TXB_CRC_LO:  cur_byte = crc_r[7:0];
      TXB_CRC_HI:  cur_byte = crc_r[15:8];
      default:     cur_byte = 8'h00;
    endcase
  end

  assign is_hdr = (idx_r != TXB_CRC_LO) && (idx_r != TXB_CRC_HI);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    crc_nxt  = crc_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = TXB_SLAVE;
      crc_nxt  = CRC_INIT;
    end else if (advance && busy_r) begin
      idx_nxt = idx_r + 3'd1;
      if (is_hdr) begin
        crc_nxt = crc16_byte(crc_r, cur_byte);
      end
      if (idx_r == TXB_CRC_HI) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= TXB_SLAVE;
      crc_r  <= CRC_INIT;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      crc_r  <= crc_nxt;
    end
  end

  // Request fields: payload only
  always_ff @(posedge clk) begin
    if (load) begin
      slave_r <= slave;
      func_r  <= func;
      addr_r  <= start_addr;
      word_r  <= word;
    end
  end

  assign tx_st.busy = busy_r;
  assign tx_st.data = cur_byte;
  assign tx_st.last = (idx_r == TXB_CRC_HI);

endmodule

// ----- rtl/mrtu_rx_check.sv -----
// ----------------------------------------------------------------------------
// mrtu_rx_check: response byte tracker and frame checker
// Runs the CRC two bytes behind the input, keeps the header bytes and counts
// the frame; on the final byte builds the one-beat status report.
// ----------------------------------------------------------------------------
module mrtu_rx_check #(
  parameter  int MAX_FRAME = 256,
  localparam int CntW      = $clog2(MAX_FRAME + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_load,
  input  logic [7:0]          req_slave,
  input  logic                rx_fire,
  input  logic [7:0]          rx_byte,
  input  logic                frame_end,
  output mrtu_pkg::mrtu_rpt_t rpt
);
  import mrtu_pkg::*;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_FRAME);

  logic [7:0]      exp_slave_r, exp_slave_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      d0_r, d0_nxt, d1_r, d1_nxt;
  logic [7:0]      fb0_r, fb0_nxt, fb1_r, fb1_nxt, fb3_r, fb3_nxt, fb4_r, fb4_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [2:0]      status;
  logic [15:0]     value;

  always_comb begin
    exp_slave_nxt = req_load ? req_slave : exp_slave_r;
    crc_nxt = crc_r;
    d0_nxt  = d0_r;
    d1_nxt  = d1_r;
    fb0_nxt = fb0_r;
    fb1_nxt = fb1_r;
    fb3_nxt = fb3_r;
    fb4_nxt = fb4_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (rx_fire) begin
      if (cnt_r >= MaxCnt) begin
        ovf_nxt = 1'b1;  // drop the byte
      end else begin
        if (cnt_r >= CntW'(2)) begin
          crc_nxt = crc16_byte(crc_r, d0_r);
        end
        d0_nxt = d1_r;
        d1_nxt = rx_byte;
        if (cnt_r == CntW'(0)) fb0_nxt = rx_byte;
        if (cnt_r == CntW'(1)) fb1_nxt = rx_byte;
        if (cnt_r == CntW'(3)) fb3_nxt = rx_byte;
        if (cnt_r == CntW'(4)) fb4_nxt = rx_byte;
        cnt_nxt = cnt_r + CntW'(1);
      end
    end
  end

  // Checks in priority order, on the state after this byte
  always_comb begin
    value = 16'h0000;
    if (ovf_nxt) begin
      status = ST_OVERFLOW;
    end else if (cnt_nxt < CntW'(4)) begin
      status = ST_SHORT;
    end else if ({d1_nxt, d0_nxt} != crc_nxt) begin
      status = ST_CRC_BAD;
    end else if (fb0_nxt != exp_slave_r) begin
      status = ST_BAD_SLV;
    end else if (fb1_nxt == FUNC_READ) begin
      if (cnt_nxt < CntW'(7)) begin
        status = ST_SHORT;
      end else begin
        status = ST_READ_OK;
        value  = {fb3_nxt, fb4_nxt};
      end
    end else if (fb1_nxt == FUNC_WRITE) begin
      status = ST_WRITE_OK;
    end else begin
      status = ST_OTHER_FN;
    end
  end

  assign rpt.valid  = rx_fire && frame_end;
  assign rpt.status = status;
  assign rpt.slave  = exp_slave_r;
  assign rpt.value  = value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_slave_r <= 8'h00;
      crc_r <= CRC_INIT;
      d0_r  <= 8'h00;
      d1_r  <= 8'h00;
      fb0_r <= 8'h00;
      fb1_r <= 8'h00;
      fb3_r <= 8'h00;
      fb4_r <= 8'h00;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      exp_slave_r <= exp_slave_nxt;
      if (rx_fire && frame_end) begin
        // Clear receive state after the report
        crc_r <= CRC_INIT;
        d0_r  <= 8'h00;
        d1_r  <= 8'h00;
        fb0_r <= 8'h00;
        fb1_r <= 8'h00;
        fb3_r <= 8'h00;
        fb4_r <= 8'h00;
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        crc_r <= crc_nxt;
        d0_r  <= d0_nxt;
        d1_r  <= d1_nxt;
        fb0_r <= fb0_nxt;
        fb1_r <= fb1_nxt;
        fb3_r <= fb3_nxt;
        fb4_r <= fb4_nxt;
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

endmodule

// ----- rtl/modbus_rtu_master_frame_engine.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_master_frame_engine: Modbus RTU master framing and response check
// Request beats leave one per cycle when the output is not stalled;
//   a response report leaves in the cycle after its final byte is accepted.
//   Response bytes enter one per cycle while the input is not stalled; a
//   request stalls the input while its 8 serializer beats use the single
//   output port, so the next item enters once the last beat is loaded.
// Reset: rst_n synchronous, active low; clears serializer, receive state,
//   expected slave and the output valid.
// ----------------------------------------------------------------------------
module modbus_rtu_master_frame_engine #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_slave,
  input  logic [7:0]  in_func,
  input  logic [15:0] in_start_addr,
  input  logic [15:0] in_word,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  output logic [2:0]  out_status,
  output logic [7:0]  out_resp_slave,
  output logic [15:0] out_value
);
  import mrtu_pkg::*;

  mrtu_tx_t  tx_st;
  mrtu_rpt_t rpt;

  logic out_load_ok;
  logic in_fire, req_fire, rx_fire, tx_fire;
  logic out_valid_r, out_valid_nxt;
  logic        kind_r;
  logic [7:0]  tx_byte_r;
  logic        last_r;
  logic [2:0]  status_r;
  logic [7:0]  slave_r;
  logic [15:0] value_r;

  // The output register takes a new beat when empty or being drained.
  assign out_load_ok = !out_valid_r || !out_stall;

  // Hold the input while the serializer owns the output, or the output is full and stalled.
  // With the serializer idle, a report and a serializer beat never collide.
  assign in_stall = !out_load_ok || tx_st.busy;
  assign in_fire  = in_valid && !in_stall;
  assign req_fire = in_fire && (in_command == CMD_REQUEST);
  assign rx_fire  = in_fire && (in_command == CMD_RX_BYTE);
  assign tx_fire  = tx_st.busy && out_load_ok;

  mrtu_tx_frame u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (req_fire),
    .slave      (in_slave),
    .func       (in_func),
    .start_addr (in_start_addr),
    .word       (in_word),
    .advance    (tx_fire),
    .tx_st      (tx_st)
  );

  // Receive side also tracks the slave of the latest request.
  mrtu_rx_check #(
    .MAX_FRAME (MAX_FRAME)
  ) u_rx (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_load  (req_fire),
    .req_slave (in_slave),
    .rx_fire   (rx_fire),
    .rx_byte   (in_rx_byte),
    .frame_end (in_frame_end),
    .rpt       (rpt)
  );

  // Output valid: advance on a free slot, hold otherwise.
  assign out_valid_nxt = out_load_ok ? (tx_fire || rpt.valid) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload: unused fields of each beat kind read as zero.
  always_ff @(posedge clk) begin
    if (out_load_ok) begin
      if (tx_fire) begin
        kind_r    <= KIND_TX;
        tx_byte_r <= tx_st.data;
        last_r    <= tx_st.last;
        status_r  <= 3'd0;
        slave_r   <= 8'h00;
        value_r   <= 16'h0000;
      end else begin
        kind_r    <= KIND_REPORT;
        tx_byte_r <= 8'h00;
        last_r    <= 1'b0;
        status_r  <= rpt.status;
        slave_r   <= rpt.slave;
        value_r   <= rpt.value;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_tx_byte    = tx_byte_r;
  assign out_last       = last_r;
  assign out_status     = status_r;
  assign out_resp_slave = slave_r;
  assign out_value      = value_r;

  // An accepted request starts the serializer on the next cycle.
  a_req_starts_tx : assert property (@(posedge clk) disable iff (!rst_n)
    req_fire |=> tx_st.busy)
    else $error("serializer not busy after request");

  // A report never competes with a serializer beat.
  a_rpt_no_tx : assert property (@(posedge clk) disable iff (!rst_n)
    rpt.valid |-> !tx_st.busy)
    else $error("report while serializer busy");

  // Sending the final frame byte frees the serializer.
  a_last_frees : assert property (@(posedge clk) disable iff (!rst_n)
    (tx_fire && tx_st.last) |=> !tx_st.busy)
    else $error("serializer still busy after last beat");

endmodule
